// ----- hw/rtl/gbfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gbfp_pkg;

    // frame framing bytes
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // navigation position-velocity-time frame
    localparam logic [7:0]  NAV_CLASS  = 8'h01;
    localparam logic [7:0]  PVT_ID     = 8'h07;
    localparam logic [15:0] PVT_LENGTH = 16'd92;

    // payload byte offsets captured on the fly
    localparam logic [15:0] OFS_VALID_FLAGS = 16'd11;
    localparam logic [15:0] OFS_FIX_TYPE    = 16'd20;
    localparam logic [15:0] OFS_FIX_FLAGS   = 16'd21;
    localparam logic [15:0] OFS_NUM_SV      = 16'd23;
    localparam logic [15:0] OFS_LLH_FLAGS   = 16'd78;

    // record indexes
    localparam logic [3:0] FIELD_WORDS    = 4'd12;
    localparam logic [3:0] FIELD_FIX_TYPE = 4'd12;
    localparam logic [3:0] FIELD_NUM_SV   = 4'd13;
    localparam logic [3:0] FIELD_FLAGS    = 4'd14;

    // fix types counted as usable
    localparam logic [7:0] FIX_TYPE_MIN = 8'd2;
    localparam logic [7:0] FIX_TYPE_MAX = 8'd4;

    // controller to datapath
    typedef struct packed {
        logic       ld_class;
        logic       ld_id;
        logic       ld_len_lo;
        logic       ld_len_hi;
        logic       ld_payload;
        logic       ld_cka;
        logic       clear;
        logic       emit_hdr;
        logic       rd_en;
        logic       load_rec;
        logic [3:0] field;
        logic       last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_zero;
        logic count_done;
        logic sum_ok;
        logic is_pvt;
        logic res_busy;
        logic slot_free;
    } dp_status_t;

    // word address of each 32-bit record in the payload store
    function automatic logic [4:0] word_offset(input logic [3:0] field);
        logic [4:0] w;
        w = 5'd0;
        unique case (field)
            4'd0:    w = 5'd0;
            4'd1:    w = 5'd6;
            4'd2:    w = 5'd7;
            4'd3:    w = 5'd9;
            4'd4:    w = 5'd10;
            4'd5:    w = 5'd12;
            4'd6:    w = 5'd13;
            4'd7:    w = 5'd14;
            4'd8:    w = 5'd15;
            4'd9:    w = 5'd16;
            4'd10:   w = 5'd17;
            4'd11:   w = 5'd18;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gbfp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbfp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rx_valid,
    output logic                       rx_stall,
    input  wire gbfp_pkg::dp_status_t  st,
    output gbfp_pkg::ctrl_cmd_t        cmd
);
    import gbfp_pkg::*;

    typedef enum logic [10:0] {
        S_HUNT     = 11'b000_0000_0001,
        S_SYNC2    = 11'b000_0000_0010,
        S_CLASS    = 11'b000_0000_0100,
        S_ID       = 11'b000_0000_1000,
        S_LEN_LO   = 11'b000_0001_0000,
        S_LEN_HI   = 11'b000_0010_0000,
        S_PAYLOAD  = 11'b000_0100_0000,
        S_CK_A     = 11'b000_1000_0000,
        S_CK_B     = 11'b001_0000_0000,
        S_FETCH    = 11'b010_0000_0000,
        S_LOAD     = 11'b100_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] field_reg, field_next;
    logic       acc;

    // input is held off while records go out, and at the closing byte while a result waits
    assign rx_stall = (state_reg == S_FETCH) || (state_reg == S_LOAD) ||
                      ((state_reg == S_CK_B) && st.res_busy);
    assign acc = rx_valid && !rx_stall;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        field_next = field_reg;
        cmd        = '0;
        cmd.field  = field_reg;
        cmd.last   = (field_reg == FIELD_FLAGS);
        unique case (state_reg)
            S_HUNT:
            begin
                if (acc)
                    state_next = st.is_sync1 ? S_SYNC2 : S_HUNT;
            end
            S_SYNC2:
            begin
                if (acc)
                begin
                    priority if (st.is_sync2)
                        state_next = S_CLASS;
                    else if (st.is_sync1)
                        state_next = S_SYNC2;
                    else
                        state_next = S_HUNT;
                end
            end
            S_CLASS:
            begin
                cmd.ld_class = acc;
                if (acc)
                    state_next = S_ID;
            end
            S_ID:
            begin
                cmd.ld_id = acc;
                if (acc)
                    state_next = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                cmd.ld_len_lo = acc;
                if (acc)
                    state_next = S_LEN_HI;
            end
            S_LEN_HI:
            begin
                cmd.ld_len_hi = acc;
                if (acc)
                    state_next = st.len_zero ? S_CK_A : S_PAYLOAD;
            end
            S_PAYLOAD:
            begin
                cmd.ld_payload = acc;
                if (acc && st.count_done)
                    state_next = S_CK_A;
            end
            S_CK_A:
            begin
                cmd.ld_cka = acc;
                if (acc)
                    state_next = S_CK_B;
            end
            S_CK_B:
            begin
                if (acc)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_HUNT;
                    if (st.sum_ok)
                    begin
                        if (st.is_pvt)
                        begin
                            state_next = S_FETCH;
                            field_next = '0;
                        end
                        else
                            cmd.emit_hdr = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (st.slot_free)
                begin
                    cmd.load_rec = 1'b1;
                    if (field_reg == FIELD_FLAGS)
                        state_next = S_HUNT;
                    else
                    begin
                        field_next = field_reg + 4'd1;
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
            field_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            field_reg <= field_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/gbfp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbfp_datapath #(
    parameter int PAYLOAD_BYTES = 92
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            rx_byte,
    input  wire gbfp_pkg::ctrl_cmd_t   cmd,
    output gbfp_pkg::dp_status_t       st,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output logic [7:0]                 msg_class,
    output logic [7:0]                 msg_id,
    output logic [15:0]                payload_length,
    output logic                       is_position_fix,
    output logic [3:0]                 field_index,
    output logic [31:0]                field_value,
    output logic                       last
);
    import gbfp_pkg::*;

    localparam int WORDS = (PAYLOAD_BYTES + 3) / 4;
    localparam int AW    = $clog2(WORDS);

    // frame scalars
    logic [7:0]  class_reg, id_reg, cka_reg, sum1_reg, sum2_reg;
    logic [15:0] len_reg, count_reg;
    logic [7:0]  sum1_add;
    logic [16:0] count_inc;
    logic [15:0] len_full;

    // bytes picked off the payload for the fix-type, satellite-count and flag records
    logic [7:0] vflags_reg, fix_type_reg, fix_flags_reg, num_sv_reg, llh_flags_reg;

    // payload store, one word per four bytes
    logic [31:0]   mem [WORDS];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          store_en;

    // result register
    logic        res_valid_reg;
    logic [7:0]  res_class_reg, res_id_reg;
    logic [15:0] res_len_reg;
    logic        res_fix_reg, res_last_reg;
    logic [3:0]  res_field_reg;
    logic [31:0] res_value_reg;

    logic        fix_ok, invalid_llh, usable;
    logic [31:0] flags_word, rec_value;
    logic        res_take;

    assign sum1_add  = sum1_reg + rx_byte;
    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign len_full  = {rx_byte, len_reg[7:0]};
    assign store_en  = cmd.ld_payload && (count_reg < 16'(PAYLOAD_BYTES));
    assign rd_addr   = AW'(word_offset(cmd.field));
    assign res_take  = res_valid_reg && !res_stall;

    // status toward the controller
    always_comb
    begin
        st.is_sync1   = (rx_byte == SYNC_FIRST);
        st.is_sync2   = (rx_byte == SYNC_SECOND);
        st.len_zero   = (len_full == 16'd0);
        st.count_done = (count_inc >= {1'b0, len_reg});
        st.sum_ok     = (cka_reg == sum1_reg) && (rx_byte == sum2_reg);
        st.is_pvt     = (class_reg == NAV_CLASS) && (id_reg == PVT_ID) &&
                        (len_reg == PVT_LENGTH);
        st.res_busy   = res_valid_reg;
        st.slot_free  = !res_valid_reg || !res_stall;
    end

    // header capture, length, count and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= '0;
            id_reg    <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            sum1_reg  <= '0;
            sum2_reg  <= '0;
            cka_reg   <= '0;
        end
        else
        begin
            priority if (cmd.clear)
            begin
                class_reg <= '0;
                id_reg    <= '0;
                len_reg   <= '0;
                count_reg <= '0;
                sum1_reg  <= '0;
                sum2_reg  <= '0;
                cka_reg   <= '0;
            end
            else if (cmd.ld_class)
            begin
                class_reg <= rx_byte;
                len_reg   <= '0;
                count_reg <= '0;
                sum1_reg  <= rx_byte;
                sum2_reg  <= rx_byte;
            end
            else if (cmd.ld_id || cmd.ld_len_lo || cmd.ld_len_hi || cmd.ld_payload)
            begin
                sum1_reg <= sum1_add;
                sum2_reg <= sum2_reg + sum1_add;
                if (cmd.ld_id)
                    id_reg <= rx_byte;
                if (cmd.ld_len_lo)
                    len_reg <= {8'd0, rx_byte};
                if (cmd.ld_len_hi)
                begin
                    len_reg   <= len_full;
                    count_reg <= '0;
                end
                if (cmd.ld_payload)
                    count_reg <= count_inc[15:0];
            end
            else
                cka_reg <= cmd.ld_cka ? rx_byte : cka_reg;
        end
    end

    // flag bytes taken as they pass
    always_ff @(posedge clk)
    begin
        if (cmd.ld_payload)
        begin
            if (count_reg == OFS_VALID_FLAGS)
                vflags_reg <= rx_byte;
            if (count_reg == OFS_FIX_TYPE)
                fix_type_reg <= rx_byte;
            if (count_reg == OFS_FIX_FLAGS)
                fix_flags_reg <= rx_byte;
            if (count_reg == OFS_NUM_SV)
                num_sv_reg <= rx_byte;
            if (count_reg == OFS_LLH_FLAGS)
                llh_flags_reg <= rx_byte;
        end
    end

    // payload memory: byte-lane write, registered word read
    always_ff @(posedge clk)
    begin
        if (store_en)
            mem[count_reg[AW+1:2]][{count_reg[1:0], 3'b000} +: 8] <= rx_byte;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // usable-fix verdict and record value select
    always_comb
    begin
        fix_ok      = fix_flags_reg[0];
        invalid_llh = llh_flags_reg[0];
        usable      = fix_ok && !invalid_llh && (fix_type_reg >= FIX_TYPE_MIN) &&
                      (fix_type_reg <= FIX_TYPE_MAX);
        flags_word  = {27'd0, usable, invalid_llh, fix_ok, vflags_reg[1:0]};
        priority if (cmd.field < FIELD_WORDS)
            rec_value = rd_data_reg;
        else if (cmd.field == FIELD_FIX_TYPE)
            rec_value = {24'd0, fix_type_reg};
        else if (cmd.field == FIELD_NUM_SV)
            rec_value = {24'd0, num_sv_reg};
        else
            rec_value = flags_word;
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (cmd.emit_hdr || cmd.load_rec)
            res_valid_reg <= 1'b1;
        else if (res_take)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_hdr)
        begin
            res_class_reg <= class_reg;
            res_id_reg    <= id_reg;
            res_len_reg   <= len_reg;
            res_fix_reg   <= 1'b0;
            res_field_reg <= '0;
            res_value_reg <= '0;
            res_last_reg  <= 1'b1;
        end
        else if (cmd.load_rec)
        begin
            res_class_reg <= NAV_CLASS;
            res_id_reg    <= PVT_ID;
            res_len_reg   <= PVT_LENGTH;
            res_fix_reg   <= 1'b1;
            res_field_reg <= cmd.field;
            res_value_reg <= rec_value;
            res_last_reg  <= cmd.last;
        end
    end

    assign res_valid       = res_valid_reg;
    assign msg_class       = res_class_reg;
    assign msg_id          = res_id_reg;
    assign payload_length  = res_len_reg;
    assign is_position_fix = res_fix_reg;
    assign field_index     = res_field_reg;
    assign field_value     = res_value_reg;
    assign last            = res_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/gnss_binary_frame_parser_unit.sv -----
// header: a header result shows in the cycle after the closing checksum byte is taken
// fix records: each is fetched in S_FETCH and loaded in S_LOAD once the output is free
// throughput: one received byte per cycle during a frame; input waits the 15-record burst
// and at the closing byte while an earlier result is still held in the output register
// reset: asynchronous rst_n clears control state; the payload memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_parser_unit #(
    parameter int PAYLOAD_BYTES = 92
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       msg_class,
    output logic [7:0]       msg_id,
    output logic [15:0]      payload_length,
    output logic             is_position_fix,
    output logic [3:0]       field_index,
    output logic [31:0]      field_value,
    output logic             last
);
    import gbfp_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // frame and emission sequencing
    gbfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // storage, sums and result register
    gbfp_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (rx_byte),
        .cmd             (cmd),
        .st              (st),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .msg_class       (msg_class),
        .msg_id          (msg_id),
        .payload_length  (payload_length),
        .is_position_fix (is_position_fix),
        .field_index     (field_index),
        .field_value     (field_value),
        .last            (last)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/gbfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gbfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic        is_position_fix,
    input wire logic [3:0]  field_index,
    input wire logic [31:0] field_value,
    input wire logic        last
);
    import gbfp_pkg::*;

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(field_value) && $stable(field_index))
        else $error("result changed while stalled");

    // header result is a single closing word with zero record
    a_hdr_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_position_fix |-> last && (field_index == 4'd0) &&
        (field_value == 32'd0))
        else $error("malformed header result");

    // fix records close on the flag word only
    a_fix_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_position_fix |-> (last == (field_index == FIELD_FLAGS)) &&
        (field_index <= FIELD_FLAGS))
        else $error("fix record run closed at wrong index");

    // flag word carries only its five defined bits
    a_flag_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_position_fix && (field_index == FIELD_FLAGS) |->
        (field_value[31:5] == 27'd0))
        else $error("flag word has stray bits");

endmodule

bind gnss_binary_frame_parser_unit gbfp_checker u_gbfp_checker (.*);

`default_nettype wire
